// ----- hdl/pvas_pkg.sv -----
package pvas_pkg;

    localparam int VALUE_W     = 12;
    localparam int BEARING_W   = 10;
    localparam int SPEED_W     = 16;
    localparam int TAN_W       = 16;
    localparam int THR_W       = 12;
    localparam int COUNT_W     = 6;
    localparam int SUM_W       = 19;
    localparam int ABS_W       = 18;
    localparam int TRIG_W      = 16;
    localparam int MAG_W       = 15;
    localparam int ROUND_W     = 13;
    localparam int MUL_W       = 18;
    localparam int PROD_W      = 36;
    localparam int LEN_W       = 37;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int ROM_DEPTH   = 2 ** BEARING_W;

    localparam logic [CFG_INDEX_W-1:0] REG_TANGENT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED     = 2'd2;

    localparam logic [TAN_W-1:0]   TANGENT_RESET   = 16'd2889;
    localparam logic [THR_W-1:0]   THRESHOLD_RESET = 12'd2048;
    localparam logic [SPEED_W-1:0] SPEED_RESET     = 16'd250;

    typedef enum logic [1:0] {
        STEER_STRAIGHT = 2'd0,
        STEER_LEFT     = 2'd1,
        STEER_RIGHT    = 2'd2
    } steer_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_ACC_Y,
        ST_SQ_X,
        ST_SQ_Y,
        ST_THR,
        ST_LIM,
        ST_TAN,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        MUL_VCOS,
        MUL_VSIN,
        MUL_AXAX,
        MUL_AYAY,
        MUL_THRC,
        MUL_LIMSQ,
        MUL_AXTAN
    } mul_sel_t;

    typedef struct packed {
        logic     accept;
        mul_sel_t mul_sel;
        logic     acc_x;
        logic     acc_y;
        logic     len_load;
        logic     len_add;
        logic     near_load;
        logic     finish;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic out_busy;
    } stat_t;

    typedef struct packed {
        logic [TAN_W-1:0]   tangent;
        logic [THR_W-1:0]   threshold;
        logic [SPEED_W-1:0] speed;
    } cfg_t;

endpackage

// ----- hdl/pvas_ctrl.sv -----
module pvas_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  pvas_pkg::stat_t  stat,
    output pvas_pkg::cmd_t   cmd
);

    pvas_pkg::state_t state_reg;
    pvas_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pvas_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pvas_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = pvas_pkg::ST_MUL_X;
                end
            end
            pvas_pkg::ST_MUL_X: state_next = pvas_pkg::ST_MUL_Y;
            pvas_pkg::ST_MUL_Y: state_next = pvas_pkg::ST_ACC_Y;
            pvas_pkg::ST_ACC_Y:
            begin
                state_next = stat.last ? pvas_pkg::ST_SQ_X : pvas_pkg::ST_IDLE;
            end
            pvas_pkg::ST_SQ_X: state_next = pvas_pkg::ST_SQ_Y;
            pvas_pkg::ST_SQ_Y: state_next = pvas_pkg::ST_THR;
            pvas_pkg::ST_THR:  state_next = pvas_pkg::ST_LIM;
            pvas_pkg::ST_LIM:  state_next = pvas_pkg::ST_TAN;
            pvas_pkg::ST_TAN:  state_next = pvas_pkg::ST_DONE;
            pvas_pkg::ST_DONE:
            begin
                // hold until the previous result has left the output register
                if (!stat.out_busy)
                begin
                    state_next = pvas_pkg::ST_IDLE;
                end
            end
            default: state_next = pvas_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.mul_sel   = pvas_pkg::MUL_VCOS;
        case (state_reg)
            pvas_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            pvas_pkg::ST_MUL_X:
            begin
                cmd.mul_sel = pvas_pkg::MUL_VCOS;
            end
            pvas_pkg::ST_MUL_Y:
            begin
                cmd.mul_sel = pvas_pkg::MUL_VSIN;
                cmd.acc_x   = 1'b1;
            end
            pvas_pkg::ST_ACC_Y:
            begin
                cmd.acc_y = 1'b1;
            end
            pvas_pkg::ST_SQ_X:
            begin
                cmd.mul_sel = pvas_pkg::MUL_AXAX;
            end
            pvas_pkg::ST_SQ_Y:
            begin
                cmd.mul_sel  = pvas_pkg::MUL_AYAY;
                cmd.len_load = 1'b1;
            end
            pvas_pkg::ST_THR:
            begin
                cmd.mul_sel = pvas_pkg::MUL_THRC;
                cmd.len_add = 1'b1;
            end
            pvas_pkg::ST_LIM:
            begin
                cmd.mul_sel = pvas_pkg::MUL_LIMSQ;
            end
            pvas_pkg::ST_TAN:
            begin
                cmd.mul_sel   = pvas_pkg::MUL_AXTAN;
                cmd.near_load = 1'b1;
            end
            pvas_pkg::ST_DONE:
            begin
                // keep the tangent product steady while waiting
                cmd.mul_sel = pvas_pkg::MUL_AXTAN;
                cmd.finish  = !stat.out_busy;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- hdl/pvas_datapath.sv -----
module pvas_datapath #(
    parameter int MAX_READINGS  = 24,
    parameter int BEARING_STEPS = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pvas_pkg::cmd_t                     cmd,
    output pvas_pkg::stat_t                    stat,
    input  pvas_pkg::cfg_t                     cfg,
    input  logic [pvas_pkg::VALUE_W-1:0]       reading_value,
    input  logic [pvas_pkg::BEARING_W-1:0]     reading_bearing,
    input  logic                               last_reading,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [pvas_pkg::SPEED_W-1:0]       left_speed,
    output logic [pvas_pkg::SPEED_W-1:0]       right_speed,
    output logic [1:0]                         steer_mode
);

    localparam logic [pvas_pkg::COUNT_W-1:0] MAX_CNT = MAX_READINGS[pvas_pkg::COUNT_W-1:0];

    // Integer sine in Q1.14: Taylor series to the x^13 term on a Q30 angle.
    function automatic logic signed [pvas_pkg::TRIG_W-1:0] sine_q14(input logic [31:0] phase);
        logic [1:0]  quad;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] mag;
        quad = phase[31:30];
        r    = {34'd0, phase[29:0]};
        if (quad[0])
        begin
            r = 64'h4000_0000 - r;
        end
        x    = (r * 64'd1686629713) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        acc  = x;
        term = ((term * x2) >> 30) / 64'd6;
        acc  = acc - term;
        term = ((term * x2) >> 30) / 64'd20;
        acc  = acc + term;
        term = ((term * x2) >> 30) / 64'd42;
        acc  = acc - term;
        term = ((term * x2) >> 30) / 64'd72;
        acc  = acc + term;
        term = ((term * x2) >> 30) / 64'd110;
        acc  = acc - term;
        term = ((term * x2) >> 30) / 64'd156;
        acc  = acc + term;
        mag  = (acc + 64'd32768) >> 16;
        if (mag > 64'd16384)
        begin
            mag = 64'd16384;
        end
        return quad[1] ? -$signed(mag[pvas_pkg::TRIG_W-1:0])
                       : $signed(mag[pvas_pkg::TRIG_W-1:0]);
    endfunction

    // cosine in the upper half, sine in the lower half
    logic [2*pvas_pkg::TRIG_W-1:0] trig_rom [pvas_pkg::ROM_DEPTH];

    for (genvar i = 0; i < pvas_pkg::ROM_DEPTH; i++)
    begin : g_rom
        localparam int          K    = i % BEARING_STEPS;
        localparam logic [63:0] PH64 = (64'(K) << 32) / 64'(BEARING_STEPS);
        localparam logic [31:0] PH   = PH64[31:0];
        assign trig_rom[i] = {sine_q14(PH + 32'h4000_0000), sine_q14(PH)};
    end

    logic [pvas_pkg::VALUE_W-1:0]        value_reg;
    logic                                last_reg;
    logic signed [pvas_pkg::TRIG_W-1:0]  cos_reg;
    logic signed [pvas_pkg::TRIG_W-1:0]  sin_reg;
    logic [pvas_pkg::PROD_W-1:0]         prod_reg;
    logic [pvas_pkg::LEN_W-1:0]          len_reg;
    logic                                near_reg;
    logic signed [pvas_pkg::SUM_W-1:0]   sum_x_reg;
    logic signed [pvas_pkg::SUM_W-1:0]   sum_y_reg;
    logic [pvas_pkg::COUNT_W-1:0]        count_reg;
    logic                                out_valid_reg;
    logic [pvas_pkg::SPEED_W-1:0]        left_reg;
    logic [pvas_pkg::SPEED_W-1:0]        right_reg;
    pvas_pkg::steer_t                    mode_reg;

    logic [pvas_pkg::MAG_W-1:0]          cos_mag;
    logic [pvas_pkg::MAG_W-1:0]          sin_mag;
    logic [pvas_pkg::ABS_W-1:0]          ax;
    logic [pvas_pkg::ABS_W-1:0]          ay;
    logic [pvas_pkg::MUL_W-1:0]          mul_a;
    logic [pvas_pkg::MUL_W-1:0]          mul_b;
    logic [pvas_pkg::PROD_W-1:0]         product;
    logic [pvas_pkg::ROUND_W-1:0]        rounded;
    logic signed [pvas_pkg::SUM_W-1:0]   comp;
    logic signed [pvas_pkg::SUM_W-1:0]   sum_x_next;
    logic signed [pvas_pkg::SUM_W-1:0]   sum_y_next;
    logic                                active;
    logic                                in_cone;
    logic                                y_pos;
    logic                                x_neg;
    logic                                x_zero;
    logic                                y_zero;
    pvas_pkg::steer_t                    mode_next;

    assign cos_mag = pvas_pkg::MAG_W'(cos_reg[pvas_pkg::TRIG_W-1] ? -cos_reg : cos_reg);
    assign sin_mag = pvas_pkg::MAG_W'(sin_reg[pvas_pkg::TRIG_W-1] ? -sin_reg : sin_reg);
    assign ax      = pvas_pkg::ABS_W'(sum_x_reg[pvas_pkg::SUM_W-1] ? -sum_x_reg : sum_x_reg);
    assign ay      = pvas_pkg::ABS_W'(sum_y_reg[pvas_pkg::SUM_W-1] ? -sum_y_reg : sum_y_reg);
    assign active  = (count_reg < MAX_CNT);

    // shared multiplier operand select
    always_comb
    begin
        case (cmd.mul_sel)
            pvas_pkg::MUL_VCOS:
            begin
                mul_a = pvas_pkg::MUL_W'(value_reg);
                mul_b = pvas_pkg::MUL_W'(cos_mag);
            end
            pvas_pkg::MUL_VSIN:
            begin
                mul_a = pvas_pkg::MUL_W'(value_reg);
                mul_b = pvas_pkg::MUL_W'(sin_mag);
            end
            pvas_pkg::MUL_AXAX:
            begin
                mul_a = ax;
                mul_b = ax;
            end
            pvas_pkg::MUL_AYAY:
            begin
                mul_a = ay;
                mul_b = ay;
            end
            pvas_pkg::MUL_THRC:
            begin
                mul_a = pvas_pkg::MUL_W'(cfg.threshold);
                mul_b = pvas_pkg::MUL_W'(count_reg);
            end
            pvas_pkg::MUL_LIMSQ:
            begin
                mul_a = prod_reg[pvas_pkg::MUL_W-1:0];
                mul_b = prod_reg[pvas_pkg::MUL_W-1:0];
            end
            pvas_pkg::MUL_AXTAN:
            begin
                mul_a = ax;
                mul_b = pvas_pkg::MUL_W'(cfg.tangent);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = mul_a * mul_b;

    // round half away from zero: magnitude rounds up, sign applied after
    assign rounded    = pvas_pkg::ROUND_W'((prod_reg[26:0] + 27'd8192) >> 14);
    assign comp       = $signed(pvas_pkg::SUM_W'(rounded));
    assign sum_x_next = cos_reg[pvas_pkg::TRIG_W-1] ? sum_x_reg - comp : sum_x_reg + comp;
    assign sum_y_next = sin_reg[pvas_pkg::TRIG_W-1] ? sum_y_reg - comp : sum_y_reg + comp;

    assign x_zero = (sum_x_reg == '0);
    assign y_zero = (sum_y_reg == '0);
    assign x_neg  = sum_x_reg[pvas_pkg::SUM_W-1];
    assign y_pos  = !sum_y_reg[pvas_pkg::SUM_W-1] && !y_zero;

    assign in_cone = (x_zero && y_zero)
                   || (!x_neg && !x_zero && ({4'd0, ay, 14'd0} <= prod_reg));

    always_comb
    begin
        if (in_cone && near_reg)
        begin
            mode_next = pvas_pkg::STEER_STRAIGHT;
        end
        else if (y_pos || (y_zero && x_neg))
        begin
            mode_next = pvas_pkg::STEER_LEFT;
        end
        else
        begin
            mode_next = pvas_pkg::STEER_RIGHT;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= product;
        if (cmd.accept)
        begin
            value_reg <= reading_value;
            last_reg  <= last_reading;
            {cos_reg, sin_reg} <= trig_rom[reading_bearing];
        end
        if (cmd.len_load)
        begin
            len_reg <= pvas_pkg::LEN_W'(prod_reg);
        end
        else if (cmd.len_add)
        begin
            len_reg <= len_reg + pvas_pkg::LEN_W'(prod_reg);
        end
        if (cmd.near_load)
        begin
            near_reg <= (len_reg < pvas_pkg::LEN_W'(prod_reg));
        end
        if (cmd.finish)
        begin
            mode_reg  <= mode_next;
            left_reg  <= (mode_next == pvas_pkg::STEER_RIGHT) ? '0 : cfg.speed;
            right_reg <= (mode_next == pvas_pkg::STEER_LEFT) ? '0 : cfg.speed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                sum_x_reg <= '0;
                sum_y_reg <= '0;
                count_reg <= '0;
            end
            else
            begin
                // drop readings past the limit
                if (cmd.acc_x && active)
                begin
                    sum_x_reg <= sum_x_next;
                end
                if (cmd.acc_y && active)
                begin
                    sum_y_reg <= sum_y_next;
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.last     = last_reg;
    assign stat.out_busy = out_valid_reg && !out_ready;

    assign out_valid   = out_valid_reg;
    assign left_speed  = left_reg;
    assign right_speed = right_reg;
    assign steer_mode  = mode_reg;

endmodule

// ----- hdl/proximity_vector_avoid_steer.sv -----
// Channel  Handshake                    Payload
// -------  ---------------------------  ------------------------------------------
// in       in_valid / in_ready          reading_value, reading_bearing, last_reading
// out      out_valid / out_ready        left_speed, right_speed, steer_mode
// cfg      cfg_write (no wait)          cfg_index, cfg_data
//
// A reading goes through the accept with the trig table read, the cosine product, the sine
// product with the x accumulate, then the y accumulate.
// A last reading then goes through x^2, y^2, limit, limit^2 and x*tangent on the one 18x18
// multiplier, then the decision, plus any wait for the output register to empty.
// Input is held off while an item is in progress. Reset (asynchronous, active low) clears
// sums, count and output valid, and loads the register defaults.
module proximity_vector_avoid_steer #(
    parameter int MAX_READINGS  = 24,
    parameter int BEARING_STEPS = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [pvas_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pvas_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [pvas_pkg::VALUE_W-1:0]        reading_value,
    input  logic [pvas_pkg::BEARING_W-1:0]      reading_bearing,
    input  logic                                last_reading,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pvas_pkg::SPEED_W-1:0]        left_speed,
    output logic [pvas_pkg::SPEED_W-1:0]        right_speed,
    output logic [1:0]                          steer_mode
);

    pvas_pkg::cfg_t  cfg_reg;
    pvas_pkg::cmd_t  cmd;
    pvas_pkg::stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tangent   <= pvas_pkg::TANGENT_RESET;
            cfg_reg.threshold <= pvas_pkg::THRESHOLD_RESET;
            cfg_reg.speed     <= pvas_pkg::SPEED_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                pvas_pkg::REG_TANGENT:   cfg_reg.tangent   <= cfg_data;
                pvas_pkg::REG_THRESHOLD: cfg_reg.threshold <= cfg_data[pvas_pkg::THR_W-1:0];
                pvas_pkg::REG_SPEED:     cfg_reg.speed     <= cfg_data;
                default:                 cfg_reg           <= cfg_reg;
            endcase
        end
    end

    pvas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pvas_datapath #(
        .MAX_READINGS  (MAX_READINGS),
        .BEARING_STEPS (BEARING_STEPS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg             (cfg_reg),
        .reading_value   (reading_value),
        .reading_bearing (reading_bearing),
        .last_reading    (last_reading),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .left_speed      (left_speed),
        .right_speed     (right_speed),
        .steer_mode      (steer_mode)
    );

endmodule
